// File: rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the procedural pattern shader
// Fixed-point formats, pipeline depth, register map and the square-root step.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = 32;
    localparam int CHAN_W          = 16;
    localparam int NUM_CHAN        = 3;

    // Sum of squares and the part of it that decides the integer radius.
    localparam int SQ_W   = 2 * COORD_W;
    localparam int RAD_W  = SQ_W - 2 * COORD_FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
    // Input, square, sum, square-root stages, output.
    localparam int NUM_STAGES  = SQRT_STAGES + 4;

    // Gradient products and their rounded sum.
    localparam int PA_W = CHAN_W + 1 + COORD_W;
    localparam int PB_W = PA_W + 1;
    localparam int BL_W = PB_W + 1;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] MODE_PLAIN    = 3'd0;
    localparam logic [2:0] MODE_STRIPE   = 3'd1;
    localparam logic [2:0] MODE_GRADIENT = 3'd2;
    localparam logic [2:0] MODE_CHECKER  = 3'd3;
    localparam logic [2:0] MODE_RING     = 3'd4;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_A_RED   = 3'd1;
    localparam logic [2:0] REG_A_GREEN = 3'd2;
    localparam logic [2:0] REG_A_BLUE  = 3'd3;
    localparam logic [2:0] REG_B_RED   = 3'd4;
    localparam logic [2:0] REG_B_GREEN = 3'd5;
    localparam logic [2:0] REG_B_BLUE  = 3'd6;

    // Channel 0 is red, 1 green, 2 blue.
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_rgb;

    typedef struct packed {
        logic ld_mul;
        logic ld_sum;
    } t_blend_ctl;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    // A group of restoring square-root steps, one result bit per step, taking
    // the radicand two bits at a time from its top end.
    function automatic t_sqrt sqrt_steps(input t_sqrt s, input int unsigned first);
        t_sqrt            r;
        logic [REM_W-1:0] trial;
        r     = s;
        trial = '0;
        for (int i = 0; i < SQRT_STEPS; i++) begin
            if (first + i < ROOT_W) begin
                r.rem = {r.rem[REM_W-3:0], r.rad[RAD_W-1 -: 2]};
                r.rad = {r.rad[RAD_W-3:0], 2'b00};
                trial = {1'b0, r.root, 2'b01};
                if (r.rem >= trial) begin
                    r.rem  = r.rem - trial;
                    r.root = {r.root[ROOT_W-2:0], 1'b1};
                end else begin
                    r.root = {r.root[ROOT_W-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/pps_blend.sv
// ----------------------------------------------------------------------------
// pps_blend: gradient blend of two colors
// Two register stages: the products a*x and b*(1-x), then the rounded and
// saturated sum for each of the three channels.
// ----------------------------------------------------------------------------
module pps_blend import pps_pkg::*; (
    input  logic                      i_clk,
    input  t_blend_ctl                i_ctl,
    input  t_rgb                      i_col_a,
    input  t_rgb                      i_col_b,
    input  logic signed [COORD_W-1:0] i_x,
    output t_rgb                      o_rgb
);

    localparam logic signed [COORD_W:0] COORD_ONE = (COORD_W + 1)'(1) << COORD_FRAC_BITS;
    localparam logic signed [BL_W-1:0]  HALF      = BL_W'(1) << (COORD_FRAC_BITS - 1);

    logic signed [COORD_W:0] w_omx;
    logic signed [PA_W-1:0]  r_pa [NUM_CHAN];
    logic signed [PB_W-1:0]  r_pb [NUM_CHAN];
    logic signed [BL_W-1:0]  w_t  [NUM_CHAN];
    t_rgb                    n_rgb;
    t_rgb                    r_rgb;

    assign w_omx = COORD_ONE - {i_x[COORD_W-1], i_x};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_pa[c] <= PA_W'($signed({1'b0, i_col_a[c]})) * PA_W'(i_x);
                r_pb[c] <= PB_W'($signed({1'b0, i_col_b[c]})) * PB_W'(w_omx);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            w_t[c] = BL_W'(r_pa[c]) + BL_W'(r_pb[c]) + HALF;
            if (w_t[c][BL_W-1]) begin
                n_rgb[c] = '0;
            end else if (|w_t[c][BL_W-2:COORD_FRAC_BITS+CHAN_W]) begin
                n_rgb[c] = '1;
            end else begin
                n_rgb[c] = w_t[c][COORD_FRAC_BITS+CHAN_W-1:COORD_FRAC_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

// File: rtl/procedural_pattern_shader_unit.sv
// ----------------------------------------------------------------------------
// procedural_pattern_shader_unit: stripe, gradient, checker and ring shader
// Eight register stages lie between accepting a point and its color at the output.
// Throughput: one item per cycle while the output is not stalled; the depth is set
// by the four stages of the radius square root, four result bits per stage.
// Reset clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module procedural_pattern_shader_unit import pps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Points in: [31:0] point_x, [63:32] point_y, [95:64] point_z.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [3*COORD_W-1:0]  i_s_axis_tdata,
    // Colors out: [15:0] red, [31:16] green, [47:32] blue.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [3*CHAN_W-1:0]   o_m_axis_tdata,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int SQ0 = 3;
    localparam int LST = SQRT_STAGES - 1;

    // Configuration registers.
    logic [2:0] r_mode;
    t_rgb       r_col_a;
    t_rgb       r_col_b;
    logic       w_wr;
    logic [2:0] w_idx;

    // Stage handshake.
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_vin;
    logic [NUM_STAGES:0]   w_rdy;
    logic [NUM_STAGES-1:0] w_ld;

    // Stage 0: captured point.
    logic signed [COORD_W-1:0] w_x;
    logic signed [COORD_W-1:0] w_y;
    logic signed [COORD_W-1:0] w_z;
    logic signed [COORD_W-1:0] r0_x;
    logic [COORD_W-1:0]        r0_ax;
    logic [COORD_W-1:0]        r0_az;
    logic                      r0_stripe;
    logic                      r0_check;

    // Stage 1: squares.
    logic [SQ_W-1:0] r1_sqx;
    logic [SQ_W-1:0] r1_sqz;
    logic            r1_stripe;
    logic            r1_check;

    // Stage 2: sum of squares.
    logic [SQ_W-1:0]  w_sum;
    logic [RAD_W-1:0] r2_rad;
    logic             r2_stripe;
    logic             r2_check;

    // Square-root stages.
    t_sqrt r_sq        [SQRT_STAGES];
    logic  r_sq_stripe [SQRT_STAGES];
    logic  r_sq_check  [SQRT_STAGES];
    t_rgb  r_sq_grad   [SQRT_STAGES];

    t_blend_ctl w_blend_ctl;
    t_rgb       w_grad;

    // Output stage.
    t_rgb n_out;
    t_rgb r_out;

    // ---------------------------------------------------------------- config
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[APB_AW-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_col_a <= '0;
            r_col_b <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:    r_mode     <= pwdata[2:0];
                REG_A_RED:   r_col_a[0] <= pwdata[CHAN_W-1:0];
                REG_A_GREEN: r_col_a[1] <= pwdata[CHAN_W-1:0];
                REG_A_BLUE:  r_col_a[2] <= pwdata[CHAN_W-1:0];
                REG_B_RED:   r_col_b[0] <= pwdata[CHAN_W-1:0];
                REG_B_GREEN: r_col_b[1] <= pwdata[CHAN_W-1:0];
                REG_B_BLUE:  r_col_b[2] <= pwdata[CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE:    prdata = APB_DW'(r_mode);
            REG_A_RED:   prdata = APB_DW'(r_col_a[0]);
            REG_A_GREEN: prdata = APB_DW'(r_col_a[1]);
            REG_A_BLUE:  prdata = APB_DW'(r_col_a[2]);
            REG_B_RED:   prdata = APB_DW'(r_col_b[0]);
            REG_B_GREEN: prdata = APB_DW'(r_col_b[1]);
            REG_B_BLUE:  prdata = APB_DW'(r_col_b[2]);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------- handshake
    // A stage takes a new item when it is empty or its item moves on, so
    // bubbles close up behind a stalled output.
    assign w_rdy[NUM_STAGES] = i_m_axis_tready;
    assign w_vin[0]          = i_s_axis_tvalid;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_hs
        assign w_rdy[k] = ~r_vld[k] | w_rdy[k+1];
        if (k > 0) begin : g_vin
            assign w_vin[k] = r_vld[k-1];
        end
    end

    assign w_ld = w_rdy[NUM_STAGES-1:0] & w_vin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_axis_tdata  = r_out;

    // --------------------------------------------------------------- stage 0
    // Bit COORD_FRAC_BITS of a two's complement coordinate is the parity of
    // its true floor, negative values included.
    assign w_x = i_s_axis_tdata[COORD_W-1:0];
    assign w_y = i_s_axis_tdata[2*COORD_W-1:COORD_W];
    assign w_z = i_s_axis_tdata[3*COORD_W-1:2*COORD_W];

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r0_x      <= w_x;
            r0_ax     <= w_x[COORD_W-1] ? COORD_W'(-w_x) : w_x;
            r0_az     <= w_z[COORD_W-1] ? COORD_W'(-w_z) : w_z;
            r0_stripe <= w_x[COORD_FRAC_BITS];
            r0_check  <= w_x[COORD_FRAC_BITS] ^ w_y[COORD_FRAC_BITS] ^ w_z[COORD_FRAC_BITS];
        end
    end

    // --------------------------------------------------------------- stage 1
    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r1_sqx    <= SQ_W'(r0_ax) * SQ_W'(r0_ax);
            r1_sqz    <= SQ_W'(r0_az) * SQ_W'(r0_az);
            r1_stripe <= r0_stripe;
            r1_check  <= r0_check;
        end
    end

    // --------------------------------------------------------------- stage 2
    // The low fractional bits of the sum cannot change the integer radius,
    // so only the upper part goes into the square root.
    assign w_sum = r1_sqx + r1_sqz;

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            r2_rad    <= w_sum[SQ_W-1 -: RAD_W];
            r2_stripe <= r1_stripe;
            r2_check  <= r1_check;
        end
    end

    assign w_blend_ctl.ld_mul = w_ld[1];
    assign w_blend_ctl.ld_sum = w_ld[2];

    pps_blend u_blend (
        .i_clk   (i_clk),
        .i_ctl   (w_blend_ctl),
        .i_col_a (r_col_a),
        .i_col_b (r_col_b),
        .i_x     (r0_x),
        .o_rgb   (w_grad)
    );

    // ---------------------------------------------------------- square root
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        t_sqrt w_src;
        logic  w_src_stripe;
        logic  w_src_check;
        t_rgb  w_src_grad;

        if (k == 0) begin : g_first
            assign w_src.rad    = r2_rad;
            assign w_src.rem    = '0;
            assign w_src.root   = '0;
            assign w_src_stripe = r2_stripe;
            assign w_src_check  = r2_check;
            assign w_src_grad   = w_grad;
        end else begin : g_next
            assign w_src        = r_sq[k-1];
            assign w_src_stripe = r_sq_stripe[k-1];
            assign w_src_check  = r_sq_check[k-1];
            assign w_src_grad   = r_sq_grad[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_ld[SQ0+k]) begin
                r_sq[k]        <= sqrt_steps(w_src, k * SQRT_STEPS);
                r_sq_stripe[k] <= w_src_stripe;
                r_sq_check[k]  <= w_src_check;
                r_sq_grad[k]   <= w_src_grad;
            end
        end
    end

    // --------------------------------------------------------- output stage
    always_comb begin
        unique case (r_mode)
            MODE_PLAIN:    n_out = r_col_a;
            MODE_STRIPE:   n_out = r_sq_stripe[LST] ? r_col_a : r_col_b;
            MODE_GRADIENT: n_out = r_sq_grad[LST];
            MODE_CHECKER:  n_out = r_sq_check[LST] ? r_col_a : r_col_b;
            MODE_RING:     n_out = r_sq[LST].root[0] ? r_col_a : r_col_b;
            default:       n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[NUM_STAGES-1]) begin
            r_out <= n_out;
        end
    end

    // ----------------------------------------------------------- assertions
    // The input can only be held off when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> &r_vld)
        else $error("input stalled with an empty stage");

    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted item did not reach the first stage");

    a_stalled_squares_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !w_rdy[1]) |=> (r_vld[1] && $stable(r1_sqx) && $stable(r1_sqz)))
        else $error("stalled item lost in the squaring stage");

endmodule

// File: dv/procedural_pattern_shader_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// procedural_pattern_shader_unit_tb: self-checking bench for the pattern shader
// Streams pattern-space points into the shader under a series of register
// settings and compares every colour against a behavioural shading model.
// ----------------------------------------------------------------------------
module procedural_pattern_shader_unit_tb;
    import pps_pkg::*;

    localparam int N_RAND_PHASES = 14;
    localparam int PTS_PER_PHASE = 75;
    localparam int DRAIN_CYCLES  = NUM_STAGES + 4;
    localparam int MAX_REPORTS   = 100;
    localparam int ONE_UNIT      = 1 << COORD_FRAC_BITS;

    // Mode codes with no pattern behind them, and an index past the register map.
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [2:0] REG_UNMAPPED  = 3'd7;

    typedef struct {
        bit                   is_write;
        logic [2:0]           reg_idx;
        logic [APB_DW-1:0]    wval;
        logic [3*COORD_W-1:0] point;
    } t_work;

    typedef enum logic [4:0] {
        DRV_RUN    = 5'b00001,
        DRV_DRAIN  = 5'b00010,
        DRV_SETUP  = 5'b00100,
        DRV_ACCESS = 5'b01000,
        DRV_DONE   = 5'b10000
    } t_drv_state;
    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_CHOKE, RX_TICK} t_rx_pattern;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // [31:0] point_x, [63:32] point_y, [95:64] point_z
    logic [3*COORD_W-1:0]  i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [15:0] red, [31:16] green, [47:32] blue
    logic [3*CHAN_W-1:0]   o_m_axis_tdata;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_AW-1:0]     paddr           = '0;
    logic [APB_DW-1:0]     pwdata          = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    procedural_pattern_shader_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // Shading state as the block should hold it.
    logic [2:0]        shd_mode                = MODE_PLAIN;
    logic [CHAN_W-1:0] shd_a [NUM_CHAN]        = '{default: '0};
    logic [CHAN_W-1:0] shd_b [NUM_CHAN]        = '{default: '0};

    t_work               work_q [$];
    logic [3*CHAN_W-1:0] colour_q [$];
    string               chan_name [NUM_CHAN] = '{"red", "green", "blue"};

    int n_points      = 0;
    int n_writes      = 0;
    int writes_done   = 0;
    int pts_sent      = 0;
    int pts_accepted  = 0;
    int n_checked     = 0;
    int n_err         = 0;

    // Integer square root, one result bit at a time from the top.
    function automatic logic [31:0] radius_root(input logic [2*COORD_W-1:0] sum_sq);
        logic [31:0] root;
        logic [32:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = {1'b0, root} | (33'd1 << i);
            if ({33'd0, trial} * {33'd0, trial} <= {2'b00, sum_sq})
                root = trial[31:0];
        end
        return root;
    endfunction

    // Exact a*x + b*(1-x), rounded half up and clamped to the channel range.
    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] ca,
                                                     input logic [CHAN_W-1:0] cb,
                                                     input logic [COORD_W-1:0] xr);
        longint x, acc;
        x   = longint'($signed(xr));
        acc = longint'(ca) * x + longint'(cb) * (longint'(ONE_UNIT) - x)
              + (longint'(1) << (COORD_FRAC_BITS - 1));
        if (acc < 0)
            return '0;
        acc = acc >>> COORD_FRAC_BITS;
        if (acc > 65535)
            return '1;
        return acc[CHAN_W-1:0];
    endfunction

    function automatic logic [3*CHAN_W-1:0] shade_point(input logic [3*COORD_W-1:0] pt);
        logic [COORD_W-1:0]   px, py, pz, ax, az;
        logic [2*COORD_W-1:0] sum_sq;
        logic [31:0]          rad;
        logic                 pick_a, black;
        logic [CHAN_W-1:0]    ch [NUM_CHAN];
        px     = pt[COORD_W-1:0];
        py     = pt[2*COORD_W-1:COORD_W];
        pz     = pt[3*COORD_W-1:2*COORD_W];
        ax     = px[COORD_W-1] ? -px : px;
        az     = pz[COORD_W-1] ? -pz : pz;
        sum_sq = {32'd0, ax} * {32'd0, ax} + {32'd0, az} * {32'd0, az};
        rad    = radius_root(sum_sq);
        pick_a = 1'b0;
        black  = 1'b0;
        // Bit COORD_FRAC_BITS of a two's complement value is the parity of its floor.
        unique case (shd_mode)
            MODE_PLAIN:    pick_a = 1'b1;
            MODE_STRIPE:   pick_a = px[COORD_FRAC_BITS];
            MODE_GRADIENT: pick_a = 1'b0;
            MODE_CHECKER:  pick_a = px[COORD_FRAC_BITS] ^ py[COORD_FRAC_BITS]
                                    ^ pz[COORD_FRAC_BITS];
            MODE_RING:     pick_a = rad[COORD_FRAC_BITS];
            default:       black  = 1'b1;
        endcase
        for (int c = 0; c < NUM_CHAN; c++) begin
            if (black)
                ch[c] = '0;
            else if (shd_mode == MODE_GRADIENT)
                ch[c] = blend_chan(shd_a[c], shd_b[c], px);
            else
                ch[c] = pick_a ? shd_a[c] : shd_b[c];
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    // Input and output handshakes, sampled at the rising edge.
    always @(posedge i_clk) begin
        logic [3*CHAN_W-1:0] want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                colour_q.push_back(shade_point(i_s_axis_tdata));
                pts_accepted <= pts_accepted + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_checked <= n_checked + 1;
                if (colour_q.size() == 0) begin
                    if (n_err < MAX_REPORTS)
                        $display("%0t: unexpected colour, expected none, actual %h",
                                 $time, o_m_axis_tdata);
                    n_err++;
                end else begin
                    want = colour_q.pop_front();
                    for (int c = 0; c < NUM_CHAN; c++) begin
                        if (o_m_axis_tdata[c*CHAN_W +: CHAN_W] !== want[c*CHAN_W +: CHAN_W]) begin
                            if (n_err < MAX_REPORTS)
                                $display("%0t: %s mismatch, expected %h, actual %h", $time,
                                         chan_name[c], want[c*CHAN_W +: CHAN_W],
                                         o_m_axis_tdata[c*CHAN_W +: CHAN_W]);
                            n_err++;
                        end
                    end
                end
            end
        end
    end

    // Point and register driver.
    t_drv_state drv_state  = DRV_RUN;
    int         drain_cnt  = 0;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(negedge i_clk) begin
        t_work cur;
        if (i_rst_n) begin
            unique case (drv_state)
                DRV_RUN: begin
                    if (i_s_axis_tvalid && pts_accepted != pts_sent) begin
                        // Item still waiting for tready: hold it.
                    end else if (work_q.size() != 0 && work_q[0].is_write) begin
                        i_s_axis_tvalid <= 1'b0;
                        drain_cnt       <= 0;
                        drv_state       <= DRV_DRAIN;
                    end else if (gap_left != 0 || work_q.size() == 0) begin
                        i_s_axis_tvalid <= 1'b0;
                        if (gap_left != 0)
                            gap_left <= gap_left - 1;
                    end else if (burst_left == 0) begin
                        i_s_axis_tvalid <= 1'b0;
                        burst_left      <= $urandom_range(1, 48);
                        gap_left        <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        cur             = work_q.pop_front();
                        i_s_axis_tdata  <= cur.point;
                        i_s_axis_tvalid <= 1'b1;
                        pts_sent        <= pts_sent + 1;
                        burst_left      <= burst_left - 1;
                    end
                end
                DRV_DRAIN: begin
                    // Registers change only with the pipeline empty.
                    if (colour_q.size() == 0 && pts_accepted == pts_sent) begin
                        if (drain_cnt == DRAIN_CYCLES)
                            drv_state <= DRV_SETUP;
                        else
                            drain_cnt <= drain_cnt + 1;
                    end
                end
                DRV_SETUP: begin
                    psel      <= 1'b1;
                    penable   <= 1'b0;
                    pwrite    <= 1'b1;
                    paddr     <= {work_q[0].reg_idx, 2'b00};
                    pwdata    <= work_q[0].wval;
                    drv_state <= DRV_ACCESS;
                end
                DRV_ACCESS: begin
                    penable   <= 1'b1;
                    drv_state <= DRV_DONE;
                end
                DRV_DONE: begin
                    psel    <= 1'b0;
                    penable <= 1'b0;
                    cur     = work_q.pop_front();
                    unique case (cur.reg_idx)
                        REG_MODE:    shd_mode = cur.wval[2:0];
                        REG_A_RED:   shd_a[0] = cur.wval[CHAN_W-1:0];
                        REG_A_GREEN: shd_a[1] = cur.wval[CHAN_W-1:0];
                        REG_A_BLUE:  shd_a[2] = cur.wval[CHAN_W-1:0];
                        REG_B_RED:   shd_b[0] = cur.wval[CHAN_W-1:0];
                        REG_B_GREEN: shd_b[1] = cur.wval[CHAN_W-1:0];
                        REG_B_BLUE:  shd_b[2] = cur.wval[CHAN_W-1:0];
                        default: ;
                    endcase
                    writes_done <= writes_done + 1;
                    drv_state   <= DRV_RUN;
                end
                default: drv_state <= DRV_RUN;
            endcase
        end
    end

    // Colour sink: runs of free flow, coin-toss stalls, heavy back-pressure
    // and regularly spaced stalls.
    t_rx_pattern rx_kind     = RX_FREE;
    int          rx_seg_left = 0;

    always @(negedge i_clk) begin
        if (rx_seg_left == 0) begin
            rx_kind     <= t_rx_pattern'($urandom_range(0, 3));
            rx_seg_left <= $urandom_range(8, 80);
        end else begin
            rx_seg_left <= rx_seg_left - 1;
        end
        case (rx_kind)
            RX_FREE:  i_m_axis_tready <= 1'b1;
            RX_COIN:  i_m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_CHOKE: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:  i_m_axis_tready <= (rx_seg_left % 3 != 0);
        endcase
    end

    task automatic push_point(input logic [COORD_W-1:0] x, y, z);
        t_work w;
        w.is_write = 1'b0;
        w.reg_idx  = '0;
        w.wval     = '0;
        w.point    = {z, y, x};
        work_q.push_back(w);
        n_points++;
    endtask

    task automatic push_write(input logic [2:0] idx, input logic [APB_DW-1:0] val);
        t_work w;
        w.is_write = 1'b1;
        w.reg_idx  = idx;
        w.wval     = val;
        w.point    = '0;
        work_q.push_back(w);
        n_writes++;
    endtask

    task automatic push_config(input logic [2:0] m,
                               input logic [CHAN_W-1:0] ar, ag, ab, br, bg, bb);
        push_write(REG_MODE, APB_DW'(m));
        push_write(REG_A_RED, APB_DW'(ar));
        push_write(REG_A_GREEN, APB_DW'(ag));
        push_write(REG_A_BLUE, APB_DW'(ab));
        push_write(REG_B_RED, APB_DW'(br));
        push_write(REG_B_GREEN, APB_DW'(bg));
        push_write(REG_B_BLUE, APB_DW'(bb));
    endtask

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    // Mostly small coordinates so that floors and radii change parity often.
    function automatic logic [COORD_W-1:0] rand_coord(input logic [2:0] m);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            2, 3, 4, 5: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: begin
                if (m == MODE_GRADIENT)
                    return $urandom_range(0, ONE_UNIT);
                return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            end
        endcase
    endfunction

    initial begin
        logic [2:0] m;

        // Reset values: plain mode with black colours.
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

        push_config(MODE_STRIPE, 16'hFFFF, 16'h1234, 16'h0000, 16'h0000, 16'hABCD, 16'hFFFF);
        push_point(32'h0001_0000, 32'h0, 32'h0);
        push_point(32'hFFFF_0000, 32'h0, 32'h0);
        // Just below zero floors to minus one, which is odd.
        push_point(32'hFFFF_FFFF, 32'h0, 32'h0);
        push_point(32'h0000_8000, 32'h0, 32'h0);
        push_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);

        push_config(MODE_GRADIENT, 16'hFFFF, 16'h8000, 16'h0001, 16'h0000, 16'h4000, 16'hFFFF);
        push_point(32'h0000_0000, 32'h0, 32'h0);
        push_point(32'h0001_0000, 32'h0, 32'h0);
        // Half way gives an exact tie on the red channel.
        push_point(32'h0000_8000, 32'h0, 32'h0);
        push_point(32'hFFFF_0000, 32'h0, 32'h0);
        push_point(32'h0002_0000, 32'h0, 32'h0);
        push_point(32'h7FFF_FFFF, 32'h0, 32'h0);

        push_config(MODE_CHECKER, 16'h0FFF, 16'hF000, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000);
        push_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        push_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
        push_point(32'hFFFF_8000, 32'h0000_0000, 32'h0000_0000);
        push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

        push_config(MODE_RING, 16'h1111, 16'h2222, 16'h3333, 16'hEEEE, 16'hDDDD, 16'hCCCC);
        push_point(32'h0003_0000, 32'h0, 32'h0004_0000);
        push_point(32'h0000_0000, 32'h0, 32'h0000_0000);
        push_point(32'h8000_0000, 32'h0, 32'h8000_0000);
        push_point(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);

        // Unknown modes give black; a write past the register map changes nothing.
        push_config(MODE_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_write(REG_UNMAPPED, 32'h0000_0000);
        push_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
        push_write(REG_MODE, APB_DW'(MODE_SPARE_HI));
        push_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        push_write(REG_MODE, APB_DW'(MODE_PLAIN));
        push_point(32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);

        for (int p = 0; p < N_RAND_PHASES; p++) begin
            m = (p < 8) ? p[2:0] : 3'($urandom_range(0, 4));
            push_config(m, rand_chan(), rand_chan(), rand_chan(),
                        rand_chan(), rand_chan(), rand_chan());
            for (int k = 0; k < PTS_PER_PHASE; k++)
                push_point(rand_coord(m), rand_coord(m), rand_coord(m));
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(pts_accepted == n_points && colour_q.size() == 0 && writes_done == n_writes))
            @(negedge i_clk);
        repeat (NUM_STAGES + 8) @(posedge i_clk);

        $display("Shaded %0d points under %0d register writes across all eight modes,",
                 n_points, n_writes);
        $display("with %0d colours compared channel by channel.", n_checked);
        if (n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Run timed out with %0d of %0d points accepted.", pts_accepted, n_points);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
